/* sv/vps_pkg.sv */
// ----------------------------------------------------------------------------
// vps_pkg: shared definitions for the vibration pattern sequencer
// field widths, request codes, result bundle and the constant pattern table
// ----------------------------------------------------------------------------
package vps_pkg;

  localparam int PATTERN_TOTAL_DEF = 9;

  localparam int REQ_W = 2;
  localparam int ID_W  = 8;
  localparam int IDX_W = 4;
  localparam int MS_W  = 10;
  localparam int CNT_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2
  } req_code_t;

  typedef struct packed {
    logic [MS_W-1:0]  on_ms;
    logic [CNT_W-1:0] count;
    logic [MS_W-1:0]  gap_ms;
  } pat_row_t;

  typedef struct packed {
    logic             motor_on;
    logic             busy_res;
    logic             status;
    logic [IDX_W-1:0] active_pattern;
  } vps_res_t;

  // on time, pulse count, gap; rows above the last pattern act as off
  function automatic pat_row_t pat_row(input logic [IDX_W-1:0] idx);
    pat_row_t r;
    case (idx)
      4'd1:    r = '{on_ms: 10'd100, count: 5'd1,  gap_ms: 10'd0};
      4'd2:    r = '{on_ms: 10'd500, count: 5'd1,  gap_ms: 10'd0};
      4'd3:    r = '{on_ms: 10'd120, count: 5'd2,  gap_ms: 10'd150};
      4'd4:    r = '{on_ms: 10'd80,  count: 5'd3,  gap_ms: 10'd100};
      4'd5:    r = '{on_ms: 10'd50,  count: 5'd20, gap_ms: 10'd30};
      4'd6:    r = '{on_ms: 10'd150, count: 5'd10, gap_ms: 10'd50};
      4'd7:    r = '{on_ms: 10'd60,  count: 5'd15, gap_ms: 10'd40};
      4'd8:    r = '{on_ms: 10'd200, count: 5'd2,  gap_ms: 10'd800};
      default: r = '{on_ms: 10'd0,   count: 5'd0,  gap_ms: 10'd0};
    endcase
    return r;
  endfunction

endpackage

/* sv/vps_req_if.sv */
// ----------------------------------------------------------------------------
// vps_req_if: request channel
// valid/ready handshake carrying request type and pattern id
// ----------------------------------------------------------------------------
interface vps_req_if;
  import vps_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [ID_W-1:0]  pattern_sel;

  modport source (output valid, output req_type, output pattern_sel, input ready);
  modport sink   (input valid, input req_type, input pattern_sel, output ready);
endinterface

/* sv/vps_res_if.sv */
// ----------------------------------------------------------------------------
// vps_res_if: result channel
// valid/ready handshake carrying motor level, busy, status and active pattern
// ----------------------------------------------------------------------------
interface vps_res_if;
  import vps_pkg::*;

  logic             valid;
  logic             ready;
  logic             motor_on;
  logic             busy_res;
  logic             status;
  logic [IDX_W-1:0] active_pattern;

  modport source (output valid, output motor_on, output busy_res, output status,
                  output active_pattern, input ready);
  modport sink   (input valid, input motor_on, input busy_res, input status,
                  input active_pattern, output ready);
endinterface

/* sv/vps_core.sv */
// ----------------------------------------------------------------------------
// vps_core: sequence state and next-state logic
// holds phase and counters, advances them by one request per step
// ----------------------------------------------------------------------------
module vps_core #(
  parameter int PATTERN_TOTAL = vps_pkg::PATTERN_TOTAL_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [vps_pkg::REQ_W-1:0]    req_type,
  input  logic [vps_pkg::ID_W-1:0]     pattern_sel,
  output vps_pkg::vps_res_t            res_next
);
  import vps_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  localparam logic [ID_W-1:0] ID_LIMIT = ID_W'(PATTERN_TOTAL);

  phase_t           phase, phase_next;
  logic [IDX_W-1:0] pattern_index, pattern_index_next;
  logic [MS_W-1:0]  ms_left, ms_left_next;
  logic [CNT_W-1:0] pulses_left, pulses_left_next;

  pat_row_t         run_row;
  pat_row_t         new_row;
  logic [MS_W-1:0]  ms_dec;
  logic [CNT_W-1:0] pl_dec;
  logic             id_bad;
  logic             status_next;

  always_comb begin
    run_row = pat_row(pattern_index);
    new_row = pat_row(pattern_sel[IDX_W-1:0]);
    id_bad  = (pattern_sel >= ID_LIMIT);
    ms_dec  = (ms_left != '0) ? ms_left - MS_W'(1) : '0;
    pl_dec  = (pulses_left != '0) ? pulses_left - CNT_W'(1) : '0;

    phase_next         = phase;
    pattern_index_next = pattern_index;
    ms_left_next       = ms_left;
    pulses_left_next   = pulses_left;
    status_next        = 1'b0;

    unique case (req_type)
      REQ_TICK: begin
        unique case (phase)
          PH_ON: begin
            if (ms_dec == '0) begin
              pulses_left_next = pl_dec;
              if (pl_dec == '0) begin
                phase_next         = PH_IDLE;
                pattern_index_next = '0;
                ms_left_next       = '0;
              end else if (run_row.gap_ms != '0) begin
                phase_next   = PH_GAP;
                ms_left_next = run_row.gap_ms;
              end else begin
                ms_left_next = run_row.on_ms;
              end
            end else begin
              ms_left_next = ms_dec;
            end
          end
          PH_GAP: begin
            if (ms_dec == '0) begin
              phase_next   = PH_ON;
              ms_left_next = run_row.on_ms;
            end else begin
              ms_left_next = ms_dec;
            end
          end
          default: ;
        endcase
      end
      REQ_START: begin
        if (id_bad) begin
          status_next = 1'b1;
        end else if (new_row.on_ms == '0 || new_row.count == '0) begin
          // off pattern
          phase_next         = PH_IDLE;
          pattern_index_next = '0;
          ms_left_next       = '0;
          pulses_left_next   = '0;
        end else begin
          phase_next         = PH_ON;
          pattern_index_next = pattern_sel[IDX_W-1:0];
          ms_left_next       = new_row.on_ms;
          pulses_left_next   = new_row.count;
        end
      end
      REQ_STOP: begin
        phase_next         = PH_IDLE;
        pattern_index_next = '0;
        ms_left_next       = '0;
        pulses_left_next   = '0;
      end
      default: ;
    endcase

    res_next.motor_on       = (phase_next == PH_ON);
    res_next.busy_res       = (phase_next != PH_IDLE);
    res_next.status         = status_next;
    res_next.active_pattern = pattern_index_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      pattern_index <= '0;
      ms_left       <= '0;
      pulses_left   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      pattern_index <= pattern_index_next;
      ms_left       <= ms_left_next;
      pulses_left   <= pulses_left_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> pattern_index == '0 && pulses_left == '0 && ms_left == '0)
    else $error("idle phase with leftover sequence state");

  a_run_counters: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> pulses_left != '0 && ms_left != '0 && pattern_index != '0)
    else $error("running phase with empty counters");

  a_run_known: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> 32'(pattern_index) < PATTERN_TOTAL)
    else $error("running pattern outside the table");

  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    step && req_type == REQ_START && id_bad |=>
      phase == $past(phase) && ms_left == $past(ms_left) &&
      pulses_left == $past(pulses_left) && pattern_index == $past(pattern_index))
    else $error("rejected start changed sequence state");
`endif

endmodule

/* sv/vibration_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// vibration_pattern_sequencer: haptic motor pulse-train generator
// plays one of eight fixed on/gap patterns (ids 1 to 8, id 0 is off), advanced by 1 ms tick requests
// ----------------------------------------------------------------------------
// Every request transfer (tick, start or stop) yields exactly one result
// transfer showing the motor level, busy flag, status and running pattern
// after that request. The block takes one request per clock cycle at full
// rate while res.ready stays high; a request passes through the input
// register and then the result register before its result shows on the
// result port. The sequence state moves forward in the single cycle in
// which a request passes from the input register to the result register,
// so a stalled result port holds back at most the one request in the
// input register and req.ready drops only when both registers are full
// and res.ready is low. A start with an id at or above PATTERN_TOTAL
// returns status 1 and leaves the running sequence alone; pattern 0 and
// stop switch the motor off at once, and a start while running restarts
// from the first pulse.
// ----------------------------------------------------------------------------
module vibration_pattern_sequencer #(
  parameter int PATTERN_TOTAL = vps_pkg::PATTERN_TOTAL_DEF
) (
  input logic     clk,
  input logic     rst,
  vps_req_if.sink req,
  vps_res_if.source res
);
  import vps_pkg::*;

  // input register
  logic             in_valid;
  logic [REQ_W-1:0] in_req_type;
  logic [ID_W-1:0]  in_pattern_sel;

  // result register
  logic             res_valid;
  vps_res_t         res_data;
  vps_res_t         res_next;

  // request moves from input register into the result register
  logic             res_load;

  assign res_load  = in_valid && (!res_valid || res.ready);
  assign req.ready = !in_valid || res_load;

  vps_core #(
    .PATTERN_TOTAL (PATTERN_TOTAL)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (res_load),
    .req_type    (in_req_type),
    .pattern_sel (in_pattern_sel),
    .res_next    (res_next)
  );

  // handshake control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_req_type    <= req.req_type;
      in_pattern_sel <= req.pattern_sel;
    end
    if (res_load) begin
      res_data <= res_next;
    end
  end

  assign res.valid          = res_valid;
  assign res.motor_on       = res_data.motor_on;
  assign res.busy_res       = res_data.busy_res;
  assign res.status         = res_data.status;
  assign res.active_pattern = res_data.active_pattern;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the vibration pattern sequencer
// drives tick, start and stop requests with random pacing and back-pressure,
// predicts every result from a model of the pattern sequence and checks it
// ----------------------------------------------------------------------------
module tb;
  import vps_pkg::*;

  localparam int PAT_TOTAL    = PATTERN_TOTAL_DEF;
  localparam int EPISODES     = 14;
  localparam int MAX_POKES    = 12;
  localparam int MAX_BURST    = 30;
  // pattern 5 runs 50 ms on, 30 ms gap: this crosses into the gap and back
  localparam int CROSS_TICKS  = 85;
  localparam int DRAIN_CYCLES = 8;
  // slowest legal run stays far below this, even with every gap and stall at max
  localparam int CYCLE_LIMIT  = 100000;

  // request code with no meaning, the block must ignore it
  localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ON,
    SEQ_GAP
  } seq_phase_t;

  // pattern table: on time in ms, pulse count, gap in ms
  function automatic void pattern_shape(input int idx, output int on_ms,
                                        output int pulses, output int gap_ms);
    case (idx)
      1:       begin on_ms = 100; pulses = 1;  gap_ms = 0;   end
      2:       begin on_ms = 500; pulses = 1;  gap_ms = 0;   end
      3:       begin on_ms = 120; pulses = 2;  gap_ms = 150; end
      4:       begin on_ms = 80;  pulses = 3;  gap_ms = 100; end
      5:       begin on_ms = 50;  pulses = 20; gap_ms = 30;  end
      6:       begin on_ms = 150; pulses = 10; gap_ms = 50;  end
      7:       begin on_ms = 60;  pulses = 15; gap_ms = 40;  end
      8:       begin on_ms = 200; pulses = 2;  gap_ms = 800; end
      default: begin on_ms = 0;   pulses = 0;  gap_ms = 0;   end
    endcase
  endfunction

  // ticks from a fresh start until the sequence drops back to idle
  function automatic int full_run_ticks(input int idx);
    int on_ms;
    int pulses;
    int gap_ms;
    pattern_shape(idx, on_ms, pulses, gap_ms);
    return on_ms * pulses + gap_ms * (pulses - 1);
  endfunction

  // random pattern id in lo..hi
  function automatic logic [ID_W-1:0] rand_id(input int lo, input int hi);
    return ID_W'($urandom_range(hi, lo));
  endfunction

  // --------------------------------------------------------------------------
  // sequence model plus the queue of motor states still owed by the block
  // --------------------------------------------------------------------------
  class pattern_scoreboard;
    seq_phase_t       phase;
    logic [IDX_W-1:0] cur_pat;
    logic [MS_W-1:0]  ms_left;
    logic [CNT_W-1:0] pulses_left;
    vps_res_t         pending[$];
    int               errors;

    function new();
      go_idle();
      errors = 0;
    endfunction

    function void go_idle();
      phase       = SEQ_IDLE;
      cur_pat     = '0;
      ms_left     = '0;
      pulses_left = '0;
    endfunction

    // apply one accepted request and queue the state it should report
    function void note_request(input logic [REQ_W-1:0] rt, input logic [ID_W-1:0] pid);
      logic     status;
      int       on_ms;
      int       pulses;
      int       gap_ms;
      vps_res_t exp_res;
      status = 1'b0;
      case (rt)
        REQ_TICK: begin
          pattern_shape(int'(cur_pat), on_ms, pulses, gap_ms);
          if (phase == SEQ_ON) begin
            if (ms_left != 0) ms_left = ms_left - 1'b1;
            if (ms_left == 0) begin
              if (pulses_left != 0) pulses_left = pulses_left - 1'b1;
              if (pulses_left == 0) begin
                go_idle();
              end else if (gap_ms > 0) begin
                phase   = SEQ_GAP;
                ms_left = gap_ms[MS_W-1:0];
              end else begin
                ms_left = on_ms[MS_W-1:0];
              end
            end
          end else if (phase == SEQ_GAP) begin
            if (ms_left != 0) ms_left = ms_left - 1'b1;
            if (ms_left == 0) begin
              phase   = SEQ_ON;
              ms_left = on_ms[MS_W-1:0];
            end
          end
        end
        REQ_START: begin
          if (pid >= PAT_TOTAL || pid > 15) begin
            status = 1'b1;
          end else begin
            pattern_shape(int'(pid), on_ms, pulses, gap_ms);
            if (pid == 0 || on_ms == 0 || pulses == 0) begin
              go_idle();
            end else begin
              phase       = SEQ_ON;
              cur_pat     = pid[IDX_W-1:0];
              ms_left     = on_ms[MS_W-1:0];
              pulses_left = pulses[CNT_W-1:0];
            end
          end
        end
        REQ_STOP: go_idle();
        default: ;
      endcase
      exp_res.motor_on       = (phase == SEQ_ON);
      exp_res.busy_res       = (phase != SEQ_IDLE);
      exp_res.status         = status;
      exp_res.active_pattern = cur_pat;
      pending.push_back(exp_res);
    endfunction

    function void check_result(input vps_res_t got);
      vps_res_t exp_res;
      if (pending.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (got.motor_on !== exp_res.motor_on) begin
        $error("motor_on: expected %0d, got %0d", exp_res.motor_on, got.motor_on);
        errors++;
      end
      if (got.busy_res !== exp_res.busy_res) begin
        $error("busy_res: expected %0d, got %0d", exp_res.busy_res, got.busy_res);
        errors++;
      end
      if (got.status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, got.status);
        errors++;
      end
      if (got.active_pattern !== exp_res.active_pattern) begin
        $error("active_pattern: expected %0d, got %0d", exp_res.active_pattern,
               got.active_pattern);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  vps_req_if req_ch();
  vps_res_if res_ch();

  pattern_scoreboard sb;
  bit sender_paced;    // 0 gives a stretch of back-to-back requests
  int cycles;

  vibration_pattern_sequencer #(
    .PATTERN_TOTAL(PAT_TOTAL)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .res(res_ch.source)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog on total run length
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // one request transfer: optional idle gap, then hold valid until ready.
  // inputs move on the falling edge; ready is looked at on the rising edge.
  // valid stays high across back-to-back transfers, as it is dropped only for a gap
  task automatic send_req(input logic [REQ_W-1:0] rt, input logic [ID_W-1:0] pid);
    int gap;
    gap = sender_paced ? $urandom_range(8, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       = 1'b1;
    req_ch.req_type    = rt;
    req_ch.pattern_sel = pid;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(rt, pid);
  endtask

  // result side: random back-pressure, switching now and then to a
  // stretch where ready never drops
  initial begin
    int stall;
    int taken;
    bit receiver_paced;
    vps_res_t got;
    res_ch.ready   = 1'b0;
    taken          = 0;
    receiver_paced = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 64 == 0) receiver_paced = ($urandom_range(3, 0) != 0);
      stall = receiver_paced ? $urandom_range(8, 0) : 0;
      if (stall > 0) begin
        res_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got.motor_on       = res_ch.motor_on;
      got.busy_res       = res_ch.busy_res;
      got.status         = res_ch.status;
      got.active_pattern = res_ch.active_pattern;
      sb.check_result(got);
      taken++;
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int ep;
    int n;
    int sel;
    logic [ID_W-1:0] pid;

    sb                 = new();
    sender_paced       = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_TICK;
    req_ch.pattern_sel = '0;
    rst                = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle behavior, unknown ids, every pattern, restart and abort
    send_req(REQ_TICK, 8'd0);          // tick with nothing running
    send_req(REQ_STOP, 8'd0);          // stop with nothing running
    send_req(REQ_UNDEF, 8'hFF);        // undefined request while idle
    send_req(REQ_START, 8'd9);         // first id past the table
    send_req(REQ_START, 8'hFF);        // largest id, all ones
    send_req(REQ_START, 8'd0);         // pattern off while idle
    send_req(REQ_START, 8'd1);
    send_req(REQ_TICK, 8'hFF);
    send_req(REQ_START, 8'd16);        // unknown id while running, state kept
    send_req(REQ_UNDEF, 8'd0);         // undefined request while running
    send_req(REQ_START, 8'd8);         // restart with a new pattern
    send_req(REQ_TICK, 8'd0);
    send_req(REQ_START, 8'd0);         // pattern off while running
    send_req(REQ_START, 8'd5);
    send_req(REQ_STOP, 8'hAA);         // abort a running sequence
    send_req(REQ_START, 8'd2);
    send_req(REQ_START, 8'd3);
    send_req(REQ_START, 8'd4);
    send_req(REQ_START, 8'd6);
    send_req(REQ_START, 8'd7);
    send_req(REQ_STOP, 8'd0);
    send_req(REQ_TICK, 8'hFF);
    send_req(REQ_START, 8'd15);

    // single pulse run to its end, a few idle ticks past the last pulse
    send_req(REQ_START, 8'd1);
    repeat (full_run_ticks(1) + 3) send_req(REQ_TICK, rand_id(0, 255));

    // first pulse into the gap and back on for the second pulse
    send_req(REQ_START, 8'd5);
    repeat (CROSS_TICKS) send_req(REQ_TICK, rand_id(0, 255));

    // random episodes: start a pattern, then poke it with a mix of ticks,
    // tick bursts and commands
    for (ep = 0; ep < EPISODES; ep++) begin
      sender_paced = ($urandom_range(3, 0) != 0);
      sel = $urandom_range(9, 0);
      if (sel > 1)       pid = rand_id(1, PAT_TOTAL - 1);
      else if (sel == 1) pid = 8'd0;
      else               pid = rand_id(PAT_TOTAL, 255);
      send_req(REQ_START, pid);

      n = $urandom_range(MAX_POKES, 1);
      repeat (n) begin
        sel = $urandom_range(15, 0);
        if (sel <= 9) begin
          send_req(REQ_TICK, rand_id(0, 255));
        end else if (sel == 10) begin
          send_req(REQ_STOP, rand_id(0, 255));
        end else if (sel == 11) begin
          send_req(REQ_START, rand_id(1, PAT_TOTAL - 1));
        end else if (sel == 12) begin
          send_req(REQ_START, rand_id(PAT_TOTAL, 255));
        end else if (sel == 13) begin
          send_req(REQ_START, 8'd0);
        end else if (sel == 14) begin
          send_req(REQ_UNDEF, rand_id(0, 255));
        end else begin
          // burst of ticks
          repeat ($urandom_range(MAX_BURST, 1)) send_req(REQ_TICK, rand_id(0, 255));
        end
      end
    end

    @(negedge clk);
    req_ch.valid = 1'b0;

    // drain, then a short window to catch any stray result
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* vibration_pattern_sequencer.f */
sv/vps_pkg.sv
sv/vps_req_if.sv
sv/vps_res_if.sv
sv/vps_core.sv
sv/vibration_pattern_sequencer.sv
tb/sv/tb.sv
